>>> hw/rtl/cascaded_ema_current_loop_scaler_macros.svh
// assertion macros for the ema current loop scaler
`ifndef CASCADED_EMA_CURRENT_LOOP_SCALER_MACROS_SVH
`define CASCADED_EMA_CURRENT_LOOP_SCALER_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must hold at every clock edge out of reset
`define CECLS_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CECLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CECLS_ASSERT_HOLDS(label, cond, msg)
`define CECLS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hw/rtl/cecls_pkg.sv
`default_nettype none

package cecls_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF   = 22;

    localparam int ALPHA_W  = 23;
    localparam int PERIOD_W = 16;
    localparam int VGAIN_W  = 24;
    localparam int VOFF_W   = 24;
    localparam int CGAIN_W  = 31;
    localparam int COFF_W   = 25;

    localparam int MS_W     = 8;
    localparam int COUNT_W  = 17;
    localparam int LEVEL_W  = 16;
    localparam int VOLT_W   = 18;
    localparam int CUR_W    = 25;
    localparam int CUR_FRAC = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [LEVEL_W-1:0]       LEVEL_MAX = '1;
    localparam logic [VOLT_W-1:0]        VOLT_MAX  = '1;
    localparam logic signed [CUR_W-1:0]  CUR_MIN   = -25'sd8388608;
    localparam logic signed [CUR_W-1:0]  CUR_MAX   = 25'sd16777215;

    localparam logic [ALPHA_W-1:0]       ALPHA_RST  = 23'd2635;
    localparam logic [PERIOD_W-1:0]      PERIOD_RST = 16'd1020;
    localparam logic [VGAIN_W-1:0]       VGAIN_RST  = 24'd53737;
    localparam logic signed [VOFF_W-1:0] VOFF_RST   = 24'sd3546;
    localparam logic [CGAIN_W-1:0]       CGAIN_RST  = 31'd4218298;
    localparam logic signed [COFF_W-1:0] COFF_RST   = -25'sd4915200;

    typedef enum logic [2:0] {
        REG_ALPHA       = 3'd0,
        REG_PERIOD      = 3'd1,
        REG_VOLT_GAIN   = 3'd2,
        REG_VOLT_OFFSET = 3'd3,
        REG_CUR_GAIN    = 3'd4,
        REG_CUR_OFFSET  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]       alpha;
        logic [PERIOD_W-1:0]      report_period;
        logic [VGAIN_W-1:0]       volt_gain;
        logic signed [VOFF_W-1:0] volt_offset;
        logic [CGAIN_W-1:0]       current_gain;
        logic signed [COFF_W-1:0] current_offset;
    } cfg_t;

    // seed: first beat after reset, emit: beat closes a report period
    typedef struct packed {
        logic seed;
        logic emit;
    } ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/cecls_stream_if.sv
`default_nettype none

interface cecls_in_if #(
    parameter int SAMPLE_BITS = cecls_pkg::SAMPLE_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [SAMPLE_BITS-1:0]      sample;
    logic [cecls_pkg::MS_W-1:0]  ms_elapsed;

    modport source (output valid, output sample, output ms_elapsed, input ready);
    modport sink (input valid, input sample, input ms_elapsed, output ready);
endinterface

interface cecls_out_if;
    logic                                valid;
    logic                                ready;
    logic [cecls_pkg::LEVEL_W-1:0]       filtered_level;
    logic [cecls_pkg::VOLT_W-1:0]        voltage;
    logic signed [cecls_pkg::CUR_W-1:0]  current;

    modport source (output valid, output filtered_level, output voltage, output current,
                    input ready);
    modport sink (input valid, input filtered_level, input voltage, input current,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cecls_regs.sv
`default_nettype none

module cecls_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cecls_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cecls_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cecls_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output cecls_pkg::cfg_t                   cfg
);
    import cecls_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    always_comb
    begin
        idx    = paddr[APB_ADDR_W-1:2];
        wr_en  = psel && penable && pwrite;
        pready = 1'b1;
        cfg    = cfg_reg;
        case (idx)
            REG_ALPHA:       prdata = APB_DATA_W'(cfg_reg.alpha);
            REG_PERIOD:      prdata = APB_DATA_W'(cfg_reg.report_period);
            REG_VOLT_GAIN:   prdata = APB_DATA_W'(cfg_reg.volt_gain);
            REG_VOLT_OFFSET: prdata = APB_DATA_W'(cfg_reg.volt_offset);
            REG_CUR_GAIN:    prdata = APB_DATA_W'(cfg_reg.current_gain);
            REG_CUR_OFFSET:  prdata = APB_DATA_W'(cfg_reg.current_offset);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha          <= ALPHA_RST;
            cfg_reg.report_period  <= PERIOD_RST;
            cfg_reg.volt_gain      <= VGAIN_RST;
            cfg_reg.volt_offset    <= VOFF_RST;
            cfg_reg.current_gain   <= CGAIN_RST;
            cfg_reg.current_offset <= COFF_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ALPHA:       cfg_reg.alpha          <= pwdata[ALPHA_W-1:0];
                REG_PERIOD:      cfg_reg.report_period  <= pwdata[PERIOD_W-1:0];
                REG_VOLT_GAIN:   cfg_reg.volt_gain      <= pwdata[VGAIN_W-1:0];
                REG_VOLT_OFFSET: cfg_reg.volt_offset    <= pwdata[VOFF_W-1:0];
                REG_CUR_GAIN:    cfg_reg.current_gain   <= pwdata[CGAIN_W-1:0];
                REG_CUR_OFFSET:  cfg_reg.current_offset <= pwdata[COFF_W-1:0];
                default:         ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cecls_front.sv
`default_nettype none

module cecls_front #(
    parameter int SAMPLE_BITS = cecls_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    cecls_in_if.sink                           samples,
    input  logic [cecls_pkg::PERIOD_W-1:0]     report_period,
    output logic                               push,
    input  logic                               push_ready,
    output logic [SAMPLE_BITS-1:0]             push_sample,
    output cecls_pkg::ctl_t                    push_ctl
);
    import cecls_pkg::*;

    logic               primed_reg;
    logic               primed_next;
    logic [COUNT_W-1:0] ms_count_reg;
    logic [COUNT_W-1:0] ms_count_next;
    logic [COUNT_W-1:0] ms_sum;

    always_comb
    begin
        samples.ready = push_ready;
        push          = samples.valid && push_ready;
        push_sample   = samples.sample;
        ms_sum        = ms_count_reg + COUNT_W'(samples.ms_elapsed);

        push_ctl.seed = !primed_reg;
        push_ctl.emit = primed_reg && (ms_sum >= COUNT_W'(report_period));

        primed_next   = primed_reg;
        ms_count_next = ms_count_reg;
        if (push)
        begin
            primed_next = 1'b1;
            if (primed_reg)
            begin
                ms_count_next = push_ctl.emit ? '0 : ms_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg   <= 1'b0;
            ms_count_reg <= '0;
        end
        else
        begin
            primed_reg   <= primed_next;
            ms_count_reg <= ms_count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cecls_queue.sv
`default_nettype none

module cecls_queue #(
    parameter int DATA_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              push_ready,
    input  logic              pop,
    output logic              pop_valid,
    output logic [DATA_W-1:0] pop_data
);
    import cecls_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
        pop_valid  = (count_reg != '0);
        pop_data   = entry_reg[rd_ptr_reg];
        do_push    = push && push_ready;
        do_pop     = pop && pop_valid;

        wr_ptr_next = wr_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cecls_back.sv
`default_nettype none

module cecls_back #(
    parameter int SAMPLE_BITS = cecls_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = cecls_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  logic [SAMPLE_BITS-1:0] q_sample,
    input  cecls_pkg::ctl_t        q_ctl,
    output logic                   pop,
    input  cecls_pkg::cfg_t        cfg,
    cecls_out_if.source            results
);
    import cecls_pkg::*;

    localparam int STATE_W = SAMPLE_BITS + FRAC_BITS;
    localparam int MA_W    = STATE_W + 1;
    localparam int MB_W    = CGAIN_W;
    localparam int P_W     = MA_W + MB_W + 1;
    localparam int AE_W    = FRAC_BITS + 1;
    localparam int AX_W    = (AE_W > ALPHA_W) ? AE_W : ALPHA_W;
    localparam int LV_W    = SAMPLE_BITS + 7;
    localparam int VSH_W   = SAMPLE_BITS + 16;
    localparam int VS_W    = VSH_W + 2;
    localparam int CSH_W   = VOLT_W + CGAIN_W + 1 - CUR_FRAC;
    localparam int CS_W    = CSH_W + 2;

    localparam logic [AE_W-1:0]        A_ONE  = AE_W'(1) << FRAC_BITS;
    localparam logic [P_W-1:0]         HALF_S = P_W'(1) << (FRAC_BITS - 1);
    localparam logic [P_W-1:0]         HALF_V = P_W'(1) << (FRAC_BITS + 7);
    localparam logic [P_W-1:0]         HALF_C = P_W'(1) << (CUR_FRAC - 1);
    localparam logic [STATE_W:0]       HALF_L = (STATE_W + 1)'(1) << (FRAC_BITS - 7);
    localparam logic signed [VS_W-1:0] VMAX_S = VS_W'(VOLT_MAX);
    localparam logic signed [CS_W-1:0] CMIN_S = CS_W'(CUR_MIN);
    localparam logic signed [CS_W-1:0] CMAX_S = CS_W'(CUR_MAX);

    typedef enum logic [2:0] {
        ST_MUL1,
        ST_ADD1,
        ST_MUL2,
        ST_ADD2,
        ST_MULV,
        ST_ADDV,
        ST_MULC,
        ST_ADDC
    } state_t;

    state_t                   state_reg;
    logic [STATE_W-1:0]       s1_reg;
    logic [STATE_W-1:0]       s2_reg;
    logic signed [P_W-1:0]    prod_reg;
    logic [LEVEL_W-1:0]       level_reg;
    logic [VOLT_W-1:0]        volt_reg;
    logic                     out_valid_reg;
    logic [LEVEL_W-1:0]       out_level_reg;
    logic [VOLT_W-1:0]        out_volt_reg;
    logic signed [CUR_W-1:0]  out_cur_reg;

    logic [STATE_W-1:0]       target;
    logic [AX_W-1:0]          alpha_x;
    logic [AE_W-1:0]          a_eff;
    logic signed [MA_W-1:0]   mul_a;
    logic [MB_W-1:0]          mul_b;
    logic signed [P_W-1:0]    prod;
    logic [P_W-1:0]           rnd_s;
    logic [P_W-1:0]           rnd_v;
    logic [P_W-1:0]           rnd_c;
    logic [STATE_W-1:0]       step;
    logic [STATE_W:0]         lvl_sum;
    logic [LV_W-1:0]          lvl_raw;
    logic [LEVEL_W-1:0]       lvl_sat;
    logic [VSH_W-1:0]         vsh;
    logic signed [VS_W-1:0]   vsum;
    logic [VOLT_W-1:0]        volt_sat;
    logic [CSH_W-1:0]         csh;
    logic signed [CS_W-1:0]   csum;
    logic signed [CUR_W-1:0]  cur_sat;
    logic                     out_free;

    // shared multiplier, operands picked by the sequencer step
    always_comb
    begin
        target  = {q_sample, {FRAC_BITS{1'b0}}};
        alpha_x = AX_W'(cfg.alpha);
        a_eff   = (alpha_x > AX_W'(A_ONE)) ? A_ONE : AE_W'(alpha_x);

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL1:
            begin
                mul_a = $signed({1'b0, target}) - $signed({1'b0, s1_reg});
                mul_b = MB_W'(a_eff);
            end
            ST_MUL2:
            begin
                mul_a = $signed({1'b0, s1_reg}) - $signed({1'b0, s2_reg});
                mul_b = MB_W'(a_eff);
            end
            ST_MULV:
            begin
                mul_a = $signed({1'b0, s2_reg});
                mul_b = MB_W'(cfg.volt_gain);
            end
            ST_MULC:
            begin
                mul_a = MA_W'(volt_reg);
                mul_b = cfg.current_gain;
            end
            default: ;
        endcase
        prod = mul_a * $signed({1'b0, mul_b});
    end

    always_comb
    begin
        // s + round(alpha * (x - s)), floor shift taken modulo the state width
        rnd_s = $unsigned(prod_reg) + HALF_S;
        step  = rnd_s[FRAC_BITS +: STATE_W];

        lvl_sum = {1'b0, s2_reg} + HALF_L;
        lvl_raw = lvl_sum[STATE_W -: LV_W];
        lvl_sat = (32'(lvl_raw) > 32'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(lvl_raw);

        rnd_v = $unsigned(prod_reg) + HALF_V;
        vsh   = rnd_v[FRAC_BITS + 8 +: VSH_W];
        vsum  = $signed({2'b00, vsh}) + VS_W'(cfg.volt_offset);
        if (vsum[VS_W-1])
        begin
            volt_sat = '0;
        end
        else if (vsum > VMAX_S)
        begin
            volt_sat = VOLT_MAX;
        end
        else
        begin
            volt_sat = VOLT_W'(vsum);
        end

        rnd_c = $unsigned(prod_reg) + HALF_C;
        csh   = rnd_c[CUR_FRAC +: CSH_W];
        csum  = $signed({2'b00, csh}) + CS_W'(cfg.current_offset);
        if (csum < CMIN_S)
        begin
            cur_sat = CUR_MIN;
        end
        else if (csum > CMAX_S)
        begin
            cur_sat = CUR_MAX;
        end
        else
        begin
            cur_sat = CUR_W'(csum);
        end

        out_free = !out_valid_reg || results.ready;

        case (state_reg)
            ST_MUL1: pop = q_valid && q_ctl.seed;
            ST_ADD2: pop = !q_ctl.emit;
            ST_ADDC: pop = out_free;
            default: pop = 1'b0;
        endcase

        results.valid          = out_valid_reg;
        results.filtered_level = out_level_reg;
        results.voltage        = out_volt_reg;
        results.current        = out_cur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_MUL1;
            s1_reg        <= '0;
            s2_reg        <= '0;
            prod_reg      <= '0;
            level_reg     <= '0;
            volt_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_level_reg <= '0;
            out_volt_reg  <= '0;
            out_cur_reg   <= '0;
        end
        else
        begin
            if ((state_reg == ST_ADDC) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_MUL1:
                begin
                    if (q_valid)
                    begin
                        if (q_ctl.seed)
                        begin
                            s1_reg <= target;
                            s2_reg <= target;
                        end
                        else
                        begin
                            prod_reg  <= prod;
                            state_reg <= ST_ADD1;
                        end
                    end
                end
                ST_ADD1:
                begin
                    s1_reg    <= s1_reg + step;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    prod_reg  <= prod;
                    state_reg <= ST_ADD2;
                end
                ST_ADD2:
                begin
                    s2_reg    <= s2_reg + step;
                    state_reg <= q_ctl.emit ? ST_MULV : ST_MUL1;
                end
                ST_MULV:
                begin
                    prod_reg  <= prod;
                    level_reg <= lvl_sat;
                    state_reg <= ST_ADDV;
                end
                ST_ADDV:
                begin
                    volt_reg  <= volt_sat;
                    state_reg <= ST_MULC;
                end
                ST_MULC:
                begin
                    prod_reg  <= prod;
                    state_reg <= ST_ADDC;
                end
                ST_ADDC:
                begin
                    if (out_free)
                    begin
                        out_level_reg <= level_reg;
                        out_volt_reg  <= volt_reg;
                        out_cur_reg   <= cur_sat;
                        state_reg     <= ST_MUL1;
                    end
                end
                default:
                begin
                    state_reg <= ST_MUL1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cascaded_ema_current_loop_scaler.sv
// Two-stage exponential average of ADC samples, scaled to a loop voltage and current.
// Input channel samples: one beat per ADC conversion, carrying the sample and the
// milliseconds since the previous one. Output channel results: one beat per report
// period with the filtered level, voltage and current.
// APB port: six registers at byte addresses 0 to 20, written only while idle: a user rule the block does not enforce.
// The first beat after reset seeds both averages and produces no result beat.
// A front stage takes beats, counts milliseconds and tags each beat; a two-entry
// queue feeds a sequencer that runs all products through one shared multiplier.
// In the sequencer a seed beat only loads both averages, an ordinary beat runs two
// multiply/accumulate pairs and a reporting beat runs two more pairs for voltage and
// current.
// A finished result waits in an output register; the sequencer keeps working on
// later beats and only halts at its last step while that register is still full,
// and the input side stalls once the queue fills.
// Reset clears the averages, the millisecond count, the queue and the output register
// and loads the register defaults.
`default_nettype none

`include "cascaded_ema_current_loop_scaler_macros.svh"

module cascaded_ema_current_loop_scaler #(
    parameter int SAMPLE_BITS = cecls_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = cecls_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cecls_in_if.sink                          samples,
    cecls_out_if.source                       results,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cecls_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cecls_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cecls_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import cecls_pkg::*;

    localparam int Q_W = $bits(ctl_t) + SAMPLE_BITS;

    cfg_t                   cfg;
    logic                   push;
    logic                   push_ready;
    logic [SAMPLE_BITS-1:0] push_sample;
    ctl_t                   push_ctl;
    logic                   pop;
    logic                   q_valid;
    logic [Q_W-1:0]         q_data;
    logic [SAMPLE_BITS-1:0] q_sample;
    ctl_t                   q_ctl;

    assign q_ctl    = q_data[Q_W-1 -: $bits(ctl_t)];
    assign q_sample = q_data[SAMPLE_BITS-1:0];

    cecls_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cecls_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples),
        .report_period (cfg.report_period),
        .push          (push),
        .push_ready    (push_ready),
        .push_sample   (push_sample),
        .push_ctl      (push_ctl)
    );

    cecls_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_ctl, push_sample}),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    cecls_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_sample (q_sample),
        .q_ctl    (q_ctl),
        .pop      (pop),
        .cfg      (cfg),
        .results  (results)
    );

    `CECLS_ASSERT_HOLDS(a_pop_needs_entry, !pop || q_valid, "pop from an empty queue")
    `CECLS_ASSERT_HOLDS(a_seed_never_emits, !(push && push_ctl.seed && push_ctl.emit), "seed beat tagged to emit")
    `CECLS_ASSERT_NEXT(a_emit_gives_beat, pop && q_valid && q_ctl.emit, results.valid, "reporting beat retired without a result")

endmodule

`default_nettype wire
